/* design/lss_pkg.sv */
// shared constants for the linear system solver
// fixed-point format and configuration register indexes; no dependencies
`default_nettype none

package lss_pkg;

    // fraction bits of the q16.16 format
    localparam int FRAC_BITS = 16;

    // width of the result index field
    localparam int IDX_W = 4;

    // configuration port index width and register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_THRESHOLD = 2'd1;

endpackage

`default_nettype wire

/* design/lss_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module lss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic                       re,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/lss_div.sv */
// iterative q16.16 divider, one quotient bit per cycle, saturating result
// depends on lss_pkg
`default_nettype none

module lss_div
    import lss_pkg::*;
#(
    parameter int DW = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic      [DW-1:0] quot,
    output logic               done
);

    localparam int NW   = DW + FRAC_BITS;
    localparam int CNTW = $clog2(NW + 1);
    localparam logic [NW-1:0] POS_MAX = {{(NW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
    localparam logic [NW-1:0] NEG_MAX = NW'(1) << (DW - 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]   q_reg, q_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   dmag_reg, dmag_next;
    logic            neg_reg, neg_next;

    logic [DW-1:0]   num_abs;
    logic [DW-1:0]   den_abs;
    logic [DW:0]     rem_sh;
    logic            ge;

    assign num_abs = num[DW-1] ? (~num + 1'b1) : num;
    assign den_abs = den[DW-1] ? (~den + 1'b1) : den;
    assign rem_sh  = {rem_reg, q_reg[NW-1]};
    assign ge      = rem_sh >= {1'b0, dmag_reg};

    // restoring division on magnitudes
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = {num_abs, {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            dmag_next = den_abs;
            neg_next  = num[DW-1] ^ den[DW-1];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DW'(rem_sh - {1'b0, dmag_reg}) : rem_sh[DW-1:0];
            q_next   = {q_reg[NW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            q_reg    <= '0;
            rem_reg  <= '0;
            dmag_reg <= '0;
            neg_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            q_reg    <= q_next;
            rem_reg  <= rem_next;
            dmag_reg <= dmag_next;
            neg_reg  <= neg_next;
        end
    end

    // sign and saturation of the quotient
    always_comb
    begin
        if (!neg_reg)
        begin
            quot = (q_reg > POS_MAX) ? POS_MAX[DW-1:0] : q_reg[DW-1:0];
        end
        else
        begin
            quot = (q_reg > NEG_MAX) ? NEG_MAX[DW-1:0] : (~q_reg[DW-1:0] + 1'b1);
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

/* design/lss_mulsub.sv */
// two-stage q16.16 multiply and saturating subtract: res = sat(c - sat(round(a*b)))
// depends on lss_pkg
`default_nettype none

module lss_mulsub
    import lss_pkg::*;
#(
    parameter int DW = 32
) (
    input  wire logic                 clk,
    input  wire logic signed [DW-1:0] a,
    input  wire logic signed [DW-1:0] b,
    input  wire logic signed [DW-1:0] c,
    output logic      signed [DW-1:0] res
);

    localparam logic signed [2*DW-1:0] P_MAX = {{(DW + 1){1'b0}}, {(DW - 1){1'b1}}};
    localparam logic signed [2*DW-1:0] P_MIN = ~P_MAX;
    localparam logic signed [2*DW-1:0] P_HALF = (2*DW)'(1) << (FRAC_BITS - 1);
    localparam logic signed [DW-1:0]   V_MAX = {1'b0, {(DW - 1){1'b1}}};
    localparam logic signed [DW-1:0]   V_MIN = ~V_MAX;

    logic signed [2*DW-1:0] prod_reg;
    logic signed [2*DW-1:0] rnd;
    logic signed [2*DW-1:0] shifted;
    logic signed [DW-1:0]   qm;
    logic signed [DW:0]     diff;
    logic signed [DW-1:0]   res_reg;

    // stage 1: product
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    // stage 2: round, scale, saturate, subtract
    assign rnd     = prod_reg + P_HALF;
    assign shifted = rnd >>> FRAC_BITS;

    always_comb
    begin
        if (shifted > P_MAX)
        begin
            qm = V_MAX;
        end
        else if (shifted < P_MIN)
        begin
            qm = V_MIN;
        end
        else
        begin
            qm = shifted[DW-1:0];
        end
    end

    assign diff = {c[DW-1], c} - {qm[DW-1], qm};

    always_ff @(posedge clk)
    begin
        if (diff[DW] != diff[DW-1])
        begin
            res_reg <= diff[DW] ? V_MIN : V_MAX;
        end
        else
        begin
            res_reg <= diff[DW-1:0];
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

/* design/linear_system_solver.sv */
// Linear system solver: gaussian elimination with partial pivoting in q16.16.
// Loading takes one value per cycle into the store memory while s_tready is
// high. The item with tlast starts a solve: the store is copied to a work
// memory, then each column is pivoted (a search down the column and a row swap
// where needed), each lower row costs one quotient plus a multiply-subtract per
// element, and back substitution costs one product per term plus one quotient
// per row. All of this is set by the single read port of the work memory and
// the bit-serial divider. Results leave through an output register that holds
// each one until it is taken, and the next result waits for it. A size write
// stalls input while the load position is re-derived.
// Depends on lss_pkg, lss_ram, lss_div, lss_mulsub.
`default_nettype none

module linear_system_solver
    import lss_pkg::*;
#(
    parameter int MAX_SIZE   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // value (31:0)
    input  wire logic [31:0]          s_tdata,
    input  wire logic                 s_tlast,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // solution (31:0), index (35:32), zero fill (39:36)
    output logic [39:0]               m_tdata,
    // singular (0)
    output logic                      m_tuser,
    output logic                      m_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [16:0]          cfg_data
);

    localparam int SL    = (MAX_SIZE < 16) ? MAX_SIZE : 16;
    localparam int DW    = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
    localparam int CW    = $clog2(SL + 1);
    localparam int RW    = $clog2(SL);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam int LCW   = 9;
    localparam logic [LCW-1:0] LC_MAX  = '1;
    localparam logic [CW-1:0]  RHS_COL = CW'(SL);
    localparam logic signed [31:0] IN_MAX = $signed(32'((64'd1 << (DW - 1)) - 64'd1));
    localparam logic signed [31:0] IN_MIN = ~IN_MAX;

    localparam logic [4:0] S_LOAD     = 5'd0;
    localparam logic [4:0] S_COPY_RD  = 5'd1;
    localparam logic [4:0] S_COPY_WR  = 5'd2;
    localparam logic [4:0] S_PS_RD    = 5'd3;
    localparam logic [4:0] S_PS_CMP   = 5'd4;
    localparam logic [4:0] S_PS_CHK   = 5'd5;
    localparam logic [4:0] S_SW_RDK   = 5'd6;
    localparam logic [4:0] S_SW_RDB   = 5'd7;
    localparam logic [4:0] S_SW_WK    = 5'd8;
    localparam logic [4:0] S_SW_WB    = 5'd9;
    localparam logic [4:0] S_EL_INIT  = 5'd10;
    localparam logic [4:0] S_EL_RD    = 5'd11;
    localparam logic [4:0] S_EL_DIV   = 5'd12;
    localparam logic [4:0] S_EL_DWAIT = 5'd13;
    localparam logic [4:0] S_EL_RDK   = 5'd14;
    localparam logic [4:0] S_EL_RDI   = 5'd15;
    localparam logic [4:0] S_EL_MUL   = 5'd16;
    localparam logic [4:0] S_EL_WR    = 5'd17;
    localparam logic [4:0] S_NEXTK    = 5'd18;
    localparam logic [4:0] S_BS_RDB   = 5'd19;
    localparam logic [4:0] S_BS_ACC   = 5'd20;
    localparam logic [4:0] S_BS_RDA   = 5'd21;
    localparam logic [4:0] S_BS_RDX   = 5'd22;
    localparam logic [4:0] S_BS_MUL   = 5'd23;
    localparam logic [4:0] S_BS_SUB   = 5'd24;
    localparam logic [4:0] S_BS_UPD   = 5'd25;
    localparam logic [4:0] S_BS_RDP   = 5'd26;
    localparam logic [4:0] S_BS_DIV   = 5'd27;
    localparam logic [4:0] S_BS_DWAIT = 5'd28;
    localparam logic [4:0] S_EM_RD    = 5'd29;
    localparam logic [4:0] S_EM_OUT   = 5'd30;
    localparam logic [4:0] S_SING     = 5'd31;

    function automatic logic [AW-1:0] amap(input logic [CW-1:0] row, input logic [CW-1:0] col);
        return {row[RW-1:0], col};
    endfunction

    function automatic logic [CW-1:0] cmap(input logic [CW-1:0] j, input logic [CW-1:0] n);
        return (j == n) ? RHS_COL : j;
    endfunction

    logic [4:0]     state_reg, state_next;
    logic [4:0]     sys_reg, sys_next;
    logic [16:0]    thr_reg, thr_next;
    logic [LCW-1:0] ld_cnt_reg, ld_cnt_next;
    logic [LCW-1:0] lq_reg, lq_next;
    logic [CW-1:0]  lr_reg, lr_next;
    logic           rc_busy_reg, rc_busy_next;
    logic [3:0]     rc_cnt_reg, rc_cnt_next;
    logic [LCW-1:0] rc_num_reg, rc_num_next;
    logic [CW-1:0]  rc_rem_reg, rc_rem_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [CW-1:0]  j_reg, j_next;
    logic [CW-1:0]  k_reg, k_next;
    logic [CW-1:0]  r_reg, r_next;
    logic [CW-1:0]  best_reg, best_next;
    logic [DW:0]    mag_reg, mag_next;
    logic [DW-1:0]  piv_reg, piv_next;
    logic [DW-1:0]  t_reg, t_next;
    logic [DW-1:0]  f_reg, f_next;
    logic [DW-1:0]  acc_reg, acc_next;
    logic           o_valid_reg, o_valid_next;
    logic [31:0]    o_sol_reg, o_sol_next;
    logic [IDX_W-1:0] o_idx_reg, o_idx_next;
    logic           o_sing_reg, o_sing_next;
    logic           o_last_reg, o_last_next;

    logic [CW-1:0]  n_v;
    logic [CW-1:0]  n_m1;
    logic           in_acc;
    logic           o_free;
    logic signed [31:0] in_val;
    logic [DW-1:0]  in_sat;
    logic [CW:0]    rc_sh;
    logic           rc_ge;
    logic [DW:0]    rd_ext;
    logic [DW:0]    rd_abs;

    logic           st_we;
    logic [AW-1:0]  st_waddr;
    logic           st_re;
    logic [AW-1:0]  st_raddr;
    logic [DW-1:0]  st_rdata;
    logic           wk_we;
    logic [AW-1:0]  wk_waddr;
    logic [DW-1:0]  wk_wdata;
    logic           wk_re;
    logic [AW-1:0]  wk_raddr;
    logic [DW-1:0]  wk_rdata;
    logic [DW-1:0]  ms_a, ms_b, ms_c, ms_res;
    logic           div_start;
    logic [DW-1:0]  div_num, div_den, div_quot;
    logic           div_done;

    // effective size after clamping
    always_comb
    begin
        if (sys_reg == 5'd0)
        begin
            n_v = CW'(1);
        end
        else if (sys_reg > 5'(SL))
        begin
            n_v = CW'(SL);
        end
        else
        begin
            n_v = sys_reg[CW-1:0];
        end
    end
    assign n_m1 = n_v - 1'b1;

    assign s_tready = (state_reg == S_LOAD) && !rc_busy_reg;
    assign in_acc   = s_tvalid && s_tready;
    assign o_free   = !o_valid_reg || m_tready;

    // input saturation to the working width
    assign in_val = $signed(s_tdata);
    always_comb
    begin
        if (in_val > IN_MAX)
        begin
            in_sat = IN_MAX[DW-1:0];
        end
        else if (in_val < IN_MIN)
        begin
            in_sat = IN_MIN[DW-1:0];
        end
        else
        begin
            in_sat = in_val[DW-1:0];
        end
    end

    // store write on load
    assign st_we    = in_acc && (lq_reg <= LCW'(n_v));
    assign st_waddr = (lq_reg < LCW'(n_v)) ? amap(lq_reg[CW-1:0], lr_reg) : amap(lr_reg, RHS_COL);

    // restoring divide step for load position re-derivation
    assign rc_sh = {rc_rem_reg, rc_num_reg[LCW-1]};
    assign rc_ge = rc_sh >= {1'b0, n_v};

    // pivot magnitude of the word just read
    assign rd_ext = {wk_rdata[DW-1], wk_rdata};
    assign rd_abs = rd_ext[DW] ? (~rd_ext + 1'b1) : rd_ext;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        sys_next     = sys_reg;
        thr_next     = thr_reg;
        ld_cnt_next  = ld_cnt_reg;
        lq_next      = lq_reg;
        lr_next      = lr_reg;
        rc_busy_next = rc_busy_reg;
        rc_cnt_next  = rc_cnt_reg;
        rc_num_next  = rc_num_reg;
        rc_rem_next  = rc_rem_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        r_next       = r_reg;
        best_next    = best_reg;
        mag_next     = mag_reg;
        piv_next     = piv_reg;
        t_next       = t_reg;
        f_next       = f_reg;
        acc_next     = acc_reg;
        o_valid_next = o_valid_reg && !m_tready;
        o_sol_next   = o_sol_reg;
        o_idx_next   = o_idx_reg;
        o_sing_next  = o_sing_reg;
        o_last_next  = o_last_reg;
        st_re        = 1'b0;
        st_raddr     = '0;
        wk_we        = 1'b0;
        wk_waddr     = '0;
        wk_wdata     = '0;
        wk_re        = 1'b0;
        wk_raddr     = '0;
        ms_a         = '0;
        ms_b         = '0;
        ms_c         = '0;
        div_start    = 1'b0;
        div_num      = '0;
        div_den      = '0;

        // load position re-derivation after a size write
        if (rc_busy_reg)
        begin
            rc_rem_next = rc_ge ? CW'(rc_sh - {1'b0, n_v}) : rc_sh[CW-1:0];
            rc_num_next = {rc_num_reg[LCW-2:0], rc_ge};
            rc_cnt_next = rc_cnt_reg + 1'b1;
            if (rc_cnt_reg == 4'(LCW - 1))
            begin
                rc_busy_next = 1'b0;
                lq_next      = {rc_num_reg[LCW-2:0], rc_ge};
                lr_next      = rc_ge ? CW'(rc_sh - {1'b0, n_v}) : rc_sh[CW-1:0];
            end
        end

        // configuration writes
        if (cfg_we)
        begin
            if (cfg_index == CFG_SYSTEM_SIZE)
            begin
                sys_next     = cfg_data[4:0];
                rc_busy_next = 1'b1;
                rc_cnt_next  = '0;
                rc_num_next  = ld_cnt_reg;
                rc_rem_next  = '0;
            end
            else if (cfg_index == CFG_PIVOT_THRESHOLD)
            begin
                thr_next = cfg_data;
            end
        end

        case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (ld_cnt_reg != LC_MAX)
                    begin
                        ld_cnt_next = ld_cnt_reg + 1'b1;
                    end
                    if (lr_reg == n_m1)
                    begin
                        lr_next = '0;
                        if (lq_reg != LC_MAX)
                        begin
                            lq_next = lq_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        lr_next = lr_reg + 1'b1;
                    end
                    if (s_tlast)
                    begin
                        ld_cnt_next = '0;
                        lq_next     = '0;
                        lr_next     = '0;
                        i_next      = '0;
                        j_next      = '0;
                        state_next  = S_COPY_RD;
                    end
                end
            end

            // copy the store into the work memory
            S_COPY_RD:
            begin
                st_re      = 1'b1;
                st_raddr   = amap(i_reg, cmap(j_reg, n_v));
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                wk_we    = 1'b1;
                wk_waddr = amap(i_reg, cmap(j_reg, n_v));
                wk_wdata = st_rdata;
                if (j_reg == n_v)
                begin
                    j_next = '0;
                    if (i_reg == n_m1)
                    begin
                        k_next     = '0;
                        i_next     = '0;
                        state_next = S_PS_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_COPY_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_COPY_RD;
                end
            end

            // pivot search down column k
            S_PS_RD:
            begin
                wk_re      = 1'b1;
                wk_raddr   = amap(i_reg, k_reg);
                state_next = S_PS_CMP;
            end
            S_PS_CMP:
            begin
                if ((i_reg == k_reg) || (rd_abs > mag_reg))
                begin
                    mag_next  = rd_abs;
                    best_next = i_reg;
                    piv_next  = wk_rdata;
                end
                if (i_reg == n_m1)
                begin
                    state_next = S_PS_CHK;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_PS_RD;
                end
            end
            S_PS_CHK:
            begin
                if ((mag_reg == '0) || (mag_reg < (DW + 1)'(thr_reg)))
                begin
                    state_next = S_SING;
                end
                else if (best_reg != k_reg)
                begin
                    j_next     = k_reg;
                    state_next = S_SW_RDK;
                end
                else
                begin
                    state_next = S_EL_INIT;
                end
            end

            // swap rows k and best from column k through the rhs
            S_SW_RDK:
            begin
                wk_re      = 1'b1;
                wk_raddr   = amap(k_reg, cmap(j_reg, n_v));
                state_next = S_SW_RDB;
            end
            S_SW_RDB:
            begin
                t_next     = wk_rdata;
                wk_re      = 1'b1;
                wk_raddr   = amap(best_reg, cmap(j_reg, n_v));
                state_next = S_SW_WK;
            end
            S_SW_WK:
            begin
                wk_we      = 1'b1;
                wk_waddr   = amap(k_reg, cmap(j_reg, n_v));
                wk_wdata   = wk_rdata;
                state_next = S_SW_WB;
            end
            S_SW_WB:
            begin
                wk_we    = 1'b1;
                wk_waddr = amap(best_reg, cmap(j_reg, n_v));
                wk_wdata = t_reg;
                if (j_reg == n_v)
                begin
                    state_next = S_EL_INIT;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_SW_RDK;
                end
            end

            // eliminate the rows below the pivot
            S_EL_INIT:
            begin
                if (k_reg == n_m1)
                begin
                    state_next = S_NEXTK;
                end
                else
                begin
                    i_next     = k_reg + 1'b1;
                    state_next = S_EL_RD;
                end
            end
            S_EL_RD:
            begin
                wk_re      = 1'b1;
                wk_raddr   = amap(i_reg, k_reg);
                state_next = S_EL_DIV;
            end
            S_EL_DIV:
            begin
                div_start  = 1'b1;
                div_num    = wk_rdata;
                div_den    = piv_reg;
                state_next = S_EL_DWAIT;
            end
            S_EL_DWAIT:
            begin
                if (div_done)
                begin
                    f_next     = div_quot;
                    j_next     = k_reg + 1'b1;
                    state_next = S_EL_RDK;
                end
            end
            S_EL_RDK:
            begin
                wk_re      = 1'b1;
                wk_raddr   = amap(k_reg, cmap(j_reg, n_v));
                state_next = S_EL_RDI;
            end
            S_EL_RDI:
            begin
                ms_a       = f_reg;
                ms_b       = wk_rdata;
                wk_re      = 1'b1;
                wk_raddr   = amap(i_reg, cmap(j_reg, n_v));
                state_next = S_EL_MUL;
            end
            S_EL_MUL:
            begin
                ms_c       = wk_rdata;
                state_next = S_EL_WR;
            end
            S_EL_WR:
            begin
                wk_we    = 1'b1;
                wk_waddr = amap(i_reg, cmap(j_reg, n_v));
                wk_wdata = ms_res;
                if (j_reg == n_v)
                begin
                    if (i_reg == n_m1)
                    begin
                        state_next = S_NEXTK;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_EL_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_EL_RDK;
                end
            end
            S_NEXTK:
            begin
                if (k_reg == n_m1)
                begin
                    r_next     = n_m1;
                    state_next = S_BS_RDB;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    i_next     = k_reg + 1'b1;
                    state_next = S_PS_RD;
                end
            end

            // back substitution, x overwrites the rhs column
            S_BS_RDB:
            begin
                wk_re      = 1'b1;
                wk_raddr   = amap(r_reg, RHS_COL);
                state_next = S_BS_ACC;
            end
            S_BS_ACC:
            begin
                acc_next = wk_rdata;
                if (r_reg == n_m1)
                begin
                    state_next = S_BS_RDP;
                end
                else
                begin
                    j_next     = r_reg + 1'b1;
                    state_next = S_BS_RDA;
                end
            end
            S_BS_RDA:
            begin
                wk_re      = 1'b1;
                wk_raddr   = amap(r_reg, j_reg);
                state_next = S_BS_RDX;
            end
            S_BS_RDX:
            begin
                t_next     = wk_rdata;
                wk_re      = 1'b1;
                wk_raddr   = amap(j_reg, RHS_COL);
                state_next = S_BS_MUL;
            end
            S_BS_MUL:
            begin
                ms_a       = t_reg;
                ms_b       = wk_rdata;
                state_next = S_BS_SUB;
            end
            S_BS_SUB:
            begin
                ms_c       = acc_reg;
                state_next = S_BS_UPD;
            end
            S_BS_UPD:
            begin
                acc_next = ms_res;
                if (j_reg == n_m1)
                begin
                    state_next = S_BS_RDP;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_BS_RDA;
                end
            end
            S_BS_RDP:
            begin
                wk_re      = 1'b1;
                wk_raddr   = amap(r_reg, r_reg);
                state_next = S_BS_DIV;
            end
            S_BS_DIV:
            begin
                div_start  = 1'b1;
                div_num    = acc_reg;
                div_den    = wk_rdata;
                state_next = S_BS_DWAIT;
            end
            S_BS_DWAIT:
            begin
                if (div_done)
                begin
                    wk_we    = 1'b1;
                    wk_waddr = amap(r_reg, RHS_COL);
                    wk_wdata = div_quot;
                    if (r_reg == '0)
                    begin
                        i_next     = '0;
                        state_next = S_EM_RD;
                    end
                    else
                    begin
                        r_next     = r_reg - 1'b1;
                        state_next = S_BS_RDB;
                    end
                end
            end

            // emit x in index order
            S_EM_RD:
            begin
                wk_re      = 1'b1;
                wk_raddr   = amap(i_reg, RHS_COL);
                state_next = S_EM_OUT;
            end
            S_EM_OUT:
            begin
                if (o_free)
                begin
                    o_valid_next = 1'b1;
                    o_sol_next   = 32'($signed(wk_rdata));
                    o_idx_next   = IDX_W'(i_reg);
                    o_sing_next  = 1'b0;
                    o_last_next  = (i_reg == n_m1);
                    if (i_reg == n_m1)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_EM_RD;
                    end
                end
            end
            S_SING:
            begin
                if (o_free)
                begin
                    o_valid_next = 1'b1;
                    o_sol_next   = '0;
                    o_idx_next   = '0;
                    o_sing_next  = 1'b1;
                    o_last_next  = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            sys_reg     <= 5'd16;
            thr_reg     <= 17'd1;
            ld_cnt_reg  <= '0;
            lq_reg      <= '0;
            lr_reg      <= '0;
            rc_busy_reg <= 1'b0;
            rc_cnt_reg  <= '0;
            rc_num_reg  <= '0;
            rc_rem_reg  <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            r_reg       <= '0;
            best_reg    <= '0;
            mag_reg     <= '0;
            piv_reg     <= '0;
            t_reg       <= '0;
            f_reg       <= '0;
            acc_reg     <= '0;
            o_valid_reg <= 1'b0;
            o_sol_reg   <= '0;
            o_idx_reg   <= '0;
            o_sing_reg  <= 1'b0;
            o_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sys_reg     <= sys_next;
            thr_reg     <= thr_next;
            ld_cnt_reg  <= ld_cnt_next;
            lq_reg      <= lq_next;
            lr_reg      <= lr_next;
            rc_busy_reg <= rc_busy_next;
            rc_cnt_reg  <= rc_cnt_next;
            rc_num_reg  <= rc_num_next;
            rc_rem_reg  <= rc_rem_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            r_reg       <= r_next;
            best_reg    <= best_next;
            mag_reg     <= mag_next;
            piv_reg     <= piv_next;
            t_reg       <= t_next;
            f_reg       <= f_next;
            acc_reg     <= acc_next;
            o_valid_reg <= o_valid_next;
            o_sol_reg   <= o_sol_next;
            o_idx_reg   <= o_idx_next;
            o_sing_reg  <= o_sing_next;
            o_last_reg  <= o_last_next;
        end
    end

    // loaded matrix and rhs
    lss_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (in_sat),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // working copy for elimination
    lss_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_work (
        .clk   (clk),
        .we    (wk_we),
        .waddr (wk_waddr),
        .wdata (wk_wdata),
        .re    (wk_re),
        .raddr (wk_raddr),
        .rdata (wk_rdata)
    );

    lss_div #(
        .DW (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .done  (div_done)
    );

    lss_mulsub #(
        .DW (DW)
    ) u_mulsub (
        .clk (clk),
        .a   (ms_a),
        .b   (ms_b),
        .c   (ms_c),
        .res (ms_res)
    );

    // output channel
    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {4'b0000, o_idx_reg, o_sol_reg};
    assign m_tuser  = o_sing_reg;
    assign m_tlast  = o_last_reg;

endmodule

`default_nettype wire
